// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a caller-supplied message, disabled during reset.
`define ASSERT_MSG(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same, with a generic message.
`define ASSERT_CLK(name, clk, rst_n, prop) \
	`ASSERT_MSG(name, clk, rst_n, prop, "lru tracker check failed")

`endif

// ===== rtl/core/lpct_pkg.sv =====
// Shared constants, types and controller/datapath interface structs of the
// LRU page cache tracker. No dependencies.
package lpct_pkg;

	localparam int MAX_WAYS  = 64;
	localparam int PAGE_BITS = 32;
	localparam int WAY_W     = $clog2(MAX_WAYS);
	localparam int PAGE_W    = 32;
	localparam int CAP_W     = 7;
	localparam int FILL_W    = 7;
	localparam int CNT_W     = 32;

	typedef logic [WAY_W-1:0]     way_t;
	typedef logic [WAY_W-1:0]     rank_t;
	typedef logic [PAGE_BITS-1:0] tag_t;
	typedef logic [PAGE_W-1:0]    page_t;
	typedef logic [CAP_W-1:0]     cap_t;
	typedef logic [FILL_W-1:0]    fill_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	localparam cap_t CAP_RESET = CAP_W'(MAX_WAYS);
	localparam way_t WAY_LAST  = WAY_W'(MAX_WAYS - 1);

	typedef enum logic {
		PH_SEARCH,
		PH_UPDATE
	} phase_t;

	typedef struct packed {
		logic   capture;   // latch request page, clear lookup result
		logic   start;     // begin a pass over all ways
		phase_t phase;
		logic   load_out;  // load result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;   // last way processed this cycle
	} ctrl_sts_t;

endpackage

// ===== rtl/core/lru_page_cache_tracker_unit.sv =====
// Top level of the LRU page cache tracker: sequencer plus datapath.
// Depends on lpct_pkg, lpct_ctrl and lpct_datapath.

// Fully associative LRU tracker over MAX_WAYS entries (64). Each request
// makes two passes over the tag and rank memories, one way per cycle: a
// lookup pass that finds the matching valid tag, then an update pass that
// ages ranks, evicts and inserts. The result register lets the next request
// in while a result waits. Capacity is taken as 1 when written 0 and as
// MAX_WAYS when written above it; write it only while the block is idle.
// The valid bits clear at reset, so the block takes requests right after
// reset with no clearing pass.
module lru_page_cache_tracker_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  lpct_pkg::cap_t  cfg_wr_data,
	input  logic            req_valid,
	output logic            req_stall,
	input  lpct_pkg::page_t page_number,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output logic            hit,
	output lpct_pkg::fill_t fill_level,
	output lpct_pkg::cnt_t  hit_total
);
	import lpct_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	lpct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	lpct_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.page_number (page_number),
		.hit         (hit),
		.fill_level  (fill_level),
		.hit_total   (hit_total)
	);

endmodule

// ===== rtl/core/lpct_ctrl.sv =====
// Sequencer of the LRU page cache tracker: request handshake, lookup and
// update passes, result register valid. Depends on lpct_pkg.
module lpct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output lpct_pkg::ctrl_cmd_t cmd,
	input  lpct_pkg::ctrl_sts_t sts
);
	import lpct_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;
	logic   rsp_load;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = (state_q == ST_RESULT) && out_free;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		cmd.phase = PH_SEARCH;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					cmd.start   = 1'b1;
				end
			end
			ST_SEARCH: begin
				if (sts.scan_done) begin
					cmd.start = 1'b1;
					cmd.phase = PH_UPDATE;
				end
			end
			ST_UPDATE: begin
			end
			ST_RESULT: begin
				cmd.load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new item may replace the one taken at this edge
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (sts.scan_done) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (sts.scan_done) state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/lpct_datapath.sv =====
// Datapath of the LRU page cache tracker: tag and rank memories, valid
// bits, scan engine, counters and result register. Depends on lpct_pkg.
module lpct_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lpct_pkg::ctrl_cmd_t cmd,
	output lpct_pkg::ctrl_sts_t sts,
	input  logic                cfg_wr_en,
	input  lpct_pkg::cap_t      cfg_wr_data,
	input  lpct_pkg::page_t     page_number,
	output logic                hit,
	output lpct_pkg::fill_t     fill_level,
	output lpct_pkg::cnt_t      hit_total
);
	import lpct_pkg::*;

	tag_t  tag_mem  [MAX_WAYS];
	rank_t rank_mem [MAX_WAYS];
	logic [MAX_WAYS-1:0] valid_q;

	cap_t   capacity_q;
	fill_t  filled_q;
	cnt_t   hit_counter_q;
	tag_t   page_q;
	phase_t phase_q;

	// scan engine: read issue, then one stage of processing
	logic  issuing_q;
	way_t  addr_q;
	logic  v_s1;
	way_t  a_s1;
	tag_t  tag_rd_s1;
	rank_t rank_rd_s1;

	logic  found_q;
	way_t  found_idx_q;
	rank_t found_rank_q;
	logic  evict_q;
	fill_t cap_m1_q;
	logic  slot_taken_q;
	fill_t cnt_q;

	logic  hit_q;
	fill_t fill_out_q;
	cnt_t  hit_total_q;

	cap_t  cap_eff;
	logic  ent_valid;
	logic  keep;
	logic  match;
	logic  upd;
	logic  rank_we;
	rank_t rank_wd;
	logic  tag_we;
	logic  vset;
	logic  vclr;
	logic  take_slot;
	fill_t cnt_d;

	always_comb begin
		cap_eff = capacity_q;
		if (capacity_q == '0) cap_eff = CAP_W'(1);
		else if (capacity_q > CAP_RESET) cap_eff = CAP_RESET;
	end

	assign ent_valid = valid_q[a_s1];
	assign upd       = v_s1 && (phase_q == PH_UPDATE);
	assign match     = v_s1 && (phase_q == PH_SEARCH) && ent_valid && !found_q &&
		(tag_rd_s1 == page_q);
	// once the fill level reaches capacity, entries ranked capacity-1 or above drop out
	assign keep      = ent_valid && !(evict_q && (FILL_W'(rank_rd_s1) >= cap_m1_q));
	assign sts.scan_done = v_s1 && (a_s1 == WAY_LAST);

	always_comb begin
		rank_we   = 1'b0;
		rank_wd   = rank_t'(rank_rd_s1 + 1'b1);
		tag_we    = 1'b0;
		vset      = 1'b0;
		vclr      = 1'b0;
		take_slot = 1'b0;
		cnt_d     = cnt_q;
		if (upd) begin
			if (found_q) begin
				if (a_s1 == found_idx_q) begin
					rank_we = 1'b1;
					rank_wd = '0;
				end else if (ent_valid && (rank_rd_s1 < found_rank_q)) begin
					rank_we = 1'b1;
				end
			end else if (keep) begin
				rank_we = 1'b1;
				cnt_d   = fill_t'(cnt_q + 1'b1);
			end else begin
				vclr = ent_valid;
				if (!slot_taken_q) begin
					take_slot = 1'b1;
					tag_we    = 1'b1;
					rank_we   = 1'b1;
					rank_wd   = '0;
					vset      = 1'b1;
					cnt_d     = fill_t'(cnt_q + 1'b1);
				end
			end
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[a_s1] <= page_q;
		if (rank_we) rank_mem[a_s1] <= rank_wd;
		tag_rd_s1  <= tag_mem[addr_q];
		rank_rd_s1 <= rank_mem[addr_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		a_s1 <= addr_q;
		if (cmd.capture) page_q <= page_number[PAGE_BITS-1:0];
		if (match) begin
			found_idx_q  <= a_s1;
			found_rank_q <= rank_rd_s1;
		end
		if (cmd.start) cap_m1_q <= fill_t'(cap_eff - 1'b1);
		if (cmd.load_out) begin
			hit_q       <= found_q;
			fill_out_q  <= filled_q;
			hit_total_q <= hit_counter_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			capacity_q    <= CAP_RESET;
			filled_q      <= '0;
			hit_counter_q <= '0;
			phase_q       <= PH_SEARCH;
			issuing_q     <= 1'b0;
			addr_q        <= '0;
			v_s1          <= 1'b0;
			found_q       <= 1'b0;
			evict_q       <= 1'b0;
			slot_taken_q  <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (cfg_wr_en) capacity_q <= cfg_wr_data;
			v_s1 <= issuing_q;
			if (issuing_q) begin
				addr_q <= way_t'(addr_q + 1'b1);
				if (addr_q == WAY_LAST) issuing_q <= 1'b0;
			end
			if (cmd.start) begin
				issuing_q    <= 1'b1;
				addr_q       <= '0;
				phase_q      <= cmd.phase;
				evict_q      <= (filled_q >= FILL_W'(cap_eff));
				slot_taken_q <= 1'b0;
				cnt_q        <= '0;
			end
			if (cmd.capture) found_q <= 1'b0;
			if (match) found_q <= 1'b1;
			if (upd) begin
				cnt_q <= cnt_d;
				if (take_slot) slot_taken_q <= 1'b1;
				if (vset) valid_q[a_s1] <= 1'b1;
				else if (vclr) valid_q[a_s1] <= 1'b0;
			end
			if (upd && sts.scan_done) begin
				if (found_q) begin
					if (hit_counter_q != '1) hit_counter_q <= cnt_t'(hit_counter_q + 1'b1);
				end else begin
					filled_q <= cnt_d;
				end
			end
		end
	end

	assign hit        = hit_q;
	assign fill_level = fill_out_q;
	assign hit_total  = hit_total_q;

endmodule

// ===== rtl/core/lpct_checker.sv =====
// Port-level checks of the LRU page cache tracker, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lpct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic        hit,
	input logic [6:0]  fill_level,
	input logic [31:0] hit_total
);

	// a held result keeps its count
	`ASSERT_CLK(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(hit_total))
	// one request in flight: acceptance closes the request side
	`ASSERT_CLK(a_one_in_flight, clk, arst_n, req_valid && !req_stall |=> req_stall)
	// after any request at least one entry is present, never more than the ways
	`ASSERT_CLK(a_fill_range, clk, arst_n, rsp_valid |-> fill_level != 7'd0 && fill_level <= 7'd64)
	// a hit is always counted
	`ASSERT_MSG(a_hit_counted, clk, arst_n, rsp_valid && hit |-> hit_total != 32'd0, "hit uncounted")

endmodule

bind lru_page_cache_tracker_unit lpct_checker u_lpct_checker (.*);

// ===== bench/tb_lru_page_cache_tracker_unit.sv =====
// Self-checking bench for lru_page_cache_tracker_unit: random bursty requests,
// random result stalls and capacity changes, checked against an in-bench LRU predictor.
// Depends on lpct_pkg and the RTL top level.
module tb_lru_page_cache_tracker_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import lpct_pkg::*;

	localparam int CYCLE_LIMIT   = 2_500_000;
	localparam int SETTLE_CYCLES = 2 * MAX_WAYS + 12;

	typedef struct {
		logic  hit;
		fill_t fill;
		cnt_t  total;
	} lookup_result_t;

	// LRU state predictor plus the queue of results still owed by the block
	class lru_tracker_model;
		tag_t           tags[MAX_WAYS];
		bit             way_valid[MAX_WAYS];
		rank_t          ranks[MAX_WAYS];
		fill_t          filled;
		cnt_t           hit_count;
		cap_t           capacity;
		lookup_result_t pending_results[$];
		int             error_count;
		int             requests;
		int             hits_seen;
		int             peak_fill;

		function new();
			foreach (way_valid[i]) begin
				way_valid[i] = 1'b0;
				ranks[i] = '0;
				tags[i] = '0;
			end
			filled = '0;
			hit_count = '0;
			capacity = CAP_RESET;
			error_count = 0;
			requests = 0;
			hits_seen = 0;
			peak_fill = 0;
		endfunction

		function void set_capacity(cap_t value);
			capacity = value;
		endfunction

		function int effective_capacity();
			if (capacity == 0)
				return 1;
			if (capacity > MAX_WAYS)
				return MAX_WAYS;
			return int'(capacity);
		endfunction

		function void note_request(page_t page);
			int             found;
			int             slot;
			int             cap;
			int             count;
			rank_t          hit_rank;
			lookup_result_t res;
			found = -1;
			cap = effective_capacity();
			for (int i = 0; i < MAX_WAYS; i++)
				if (found < 0 && way_valid[i] && tags[i] == tag_t'(page))
					found = i;
			if (found >= 0) begin
				hit_rank = ranks[found];
				for (int i = 0; i < MAX_WAYS; i++)
					if (way_valid[i] && ranks[i] < hit_rank)
						ranks[i] = ranks[i] + 1'b1;
				ranks[found] = '0;
				if (hit_count != '1)
					hit_count = hit_count + 1'b1;
				hits_seen++;
			end else begin
				count = 0;
				slot = -1;
				// full (or shrunk below fill): drop everything at or past the last rank
				if (int'(filled) >= cap) begin
					for (int i = 0; i < MAX_WAYS; i++)
						if (way_valid[i] && int'(ranks[i]) >= cap - 1)
							way_valid[i] = 1'b0;
				end
				for (int i = 0; i < MAX_WAYS; i++) begin
					if (way_valid[i]) begin
						ranks[i] = ranks[i] + 1'b1;
						count++;
					end else if (slot < 0) begin
						slot = i;
					end
				end
				if (slot >= 0) begin
					tags[slot] = tag_t'(page);
					way_valid[slot] = 1'b1;
					ranks[slot] = '0;
					count++;
				end
				filled = fill_t'(count);
			end
			if (int'(filled) > peak_fill)
				peak_fill = int'(filled);
			res.hit = (found >= 0);
			res.fill = filled;
			res.total = hit_count;
			pending_results.push_back(res);
			requests++;
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH: %s", what);
			error_count++;
		endtask

		task check_result(logic got_hit, fill_t got_fill, cnt_t got_total);
			lookup_result_t exp;
			if (pending_results.size() == 0) begin
				report_mismatch("result arrived with no request outstanding");
			end else begin
				exp = pending_results.pop_front();
				if (got_hit !== exp.hit)
					report_mismatch($sformatf("hit: got %b, expected %b", got_hit, exp.hit));
				if (got_fill !== exp.fill)
					report_mismatch($sformatf("fill_level: got %0d, expected %0d",
						got_fill, exp.fill));
				if (got_total !== exp.total)
					report_mismatch($sformatf("hit_total: got %0d, expected %0d",
						got_total, exp.total));
			end
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    cfg_wr_en;
	cap_t    cfg_wr_data;
	logic    req_valid;
	logic    req_stall;
	page_t   page_number;
	logic    rsp_valid;
	logic    rsp_stall;
	logic    hit;
	fill_t   fill_level;
	cnt_t    hit_total;

	lru_tracker_model tracker = new();
	page_t            page_pool[$];
	int               burst_left = 0;
	int               settings_used = 0;
	int               cycle_count = 0;

	lru_page_cache_tracker_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.page_number (page_number),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.hit         (hit),
		.fill_level  (fill_level),
		.hit_total   (hit_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_result(hit, fill_level, hit_total);
	end

	// result side: random runs of stall and no stall, some short and choppy
	initial begin : stall_pattern
		int run_left;
		bit level;
		rsp_stall = 1'b0;
		run_left = 0;
		level = 1'b0;
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				level = 1'($urandom_range(0, 1));
				if (level)
					run_left = $urandom_range(0, 1) ? $urandom_range(1, 4)
						: $urandom_range(5, 150);
				else
					run_left = $urandom_range(1, 300);
			end
			rsp_stall <= level;
			run_left--;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_page(input page_t page);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 8);
				2: gap = $urandom_range(9, 140);
				default: gap = 0;
			endcase
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_valid <= 1'b1;
		page_number <= page;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		tracker.note_request(page);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic write_capacity(input cap_t value);
		req_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_capacity(value);
		settings_used++;
	endtask

	// pool mixes unrelated pages with single-bit neighbors of one base page
	task automatic build_pool(input int ways);
		int    pool_size;
		page_t base;
		page_pool.delete();
		pool_size = $urandom_range((ways / 2 > 1) ? ways / 2 : 1, ways + ways / 2 + 2);
		base = $urandom;
		for (int i = 0; i < pool_size; i++) begin
			if ($urandom_range(0, 2) == 0)
				page_pool.push_back(base ^ (page_t'(1) << $urandom_range(0, PAGE_W - 1)));
			else
				page_pool.push_back($urandom);
		end
	endtask

	function automatic page_t pick_page();
		if ($urandom_range(0, 9) < 7)
			return page_pool[$urandom_range(0, page_pool.size() - 1)];
		return $urandom;
	endfunction

	initial begin : main_flow
		cap_t phase_caps[13];
		int   ways;
		int   n_items;
		phase_caps = '{7'd64, 7'd1, 7'd2, 7'd5, 7'd16, 7'd127, 7'd0, 7'd33, 7'd64,
			7'd8, 7'd3, 7'd100, 7'd64};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_valid = 1'b0;
		page_number = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset capacity: field extremes, repeat hits
		send_page(32'h0000_0000);
		send_page(32'hFFFF_FFFF);
		send_page(32'h0000_0000);
		send_page(32'h0000_0001);
		send_page(32'h8000_0000);
		send_page(32'hFFFF_FFFF);
		send_page(32'h7FFF_FFFF);
		send_page(32'h0000_0001);
		// shrink below the fill level: hit keeps all, next miss trims to capacity
		write_capacity(7'd3);
		send_page(32'h8000_0000);
		send_page(32'h1234_5678);
		send_page(32'h0000_0001);
		send_page(32'hFFFF_FFFF);
		// zero capacity behaves as one way
		write_capacity(7'd0);
		send_page(32'hA5A5_A5A5);
		send_page(32'hA5A5_A5A5);
		send_page(32'h5A5A_5A5A);
		send_page(32'hA5A5_A5A5);
		// oversized capacity clamps to the full store
		write_capacity(7'd127);
		send_page(32'h0000_FFFF);
		send_page(32'hFFFF_0000);
		send_page(32'h0000_FFFF);
		send_page(32'hA5A5_A5A5);

		for (int p = 0; p < 13; p++) begin
			write_capacity(phase_caps[p]);
			ways = tracker.effective_capacity();
			build_pool(ways);
			n_items = (ways >= 33) ? 110 : 65;
			for (int k = 0; k < n_items; k++)
				send_page(pick_page());
		end

		req_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d page requests (%0d hits) across %0d capacity writes.",
			tracker.requests, tracker.hits_seen, settings_used);
		$display("Peak fill level %0d; %0d mismatches.", tracker.peak_fill,
			tracker.error_count);
		if (tracker.error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
